FILE: hdl/pcjp_pkg.sv
`default_nettype none
package pcjp_pkg;

    // Field widths fixed by the stream format
    localparam int POS_W  = 21;
    localparam int LEN_W  = 16;
    localparam int STEP_W = 16;

    // Sine table entries are unsigned Q15, 1.0 = 32768
    localparam int TRIG_W = 16;

    // Signed length (LEN_W+1) times signed trig (TRIG_W+1)
    localparam int PROD_W     = LEN_W + TRIG_W + 2;
    localparam int FRAC_SHIFT = 15;
    localparam int INC_W      = PROD_W - FRAC_SHIFT;
    localparam int SUM_W      = POS_W + 2;

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_BASE_X = 1'b0,
        CFG_BASE_Y = 1'b1
    } pcjp_cfg_t;

    // Scaled offsets handed from the multiply stage to the accumulator
    typedef struct packed {
        logic                     first;
        logic signed [PROD_W-1:0] dx;
        logic signed [PROD_W-1:0] dy;
    } pcjp_scaled_t;

endpackage
`default_nettype wire

FILE: hdl/planar_chain_joint_positions_core.sv
`default_nettype none
// Planar serial chain forward kinematics. Each input beat carries one chain
// segment (relative angle, Q12.4 length, first-segment flag in s_tuser); each
// result beat carries the segment's end joint in signed Q16.4 with a
// saturation flag in m_tuser. One segment is taken every clock cycle unless
// m_tready holds the pipeline; each result beat passes through four register
// stages: the heading accumulator, the sine table read, the two length-by-trig
// multipliers and the saturating position accumulator. The heading and the
// last joint feed back through one adder each, so chained segments flow
// without gaps. Base point registers are written on the plain write port; the
// user must write them only while the block is idle; the block does not enforce it.
module planar_chain_joint_positions_core #(
    parameter int ANGLE_BITS      = 16,
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic [0:0]  cfg_addr,
    input  wire logic [pcjp_pkg::POS_W-1:0] cfg_wr_data,
    // Segment input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] angle_step, [31:16] seg_length
    input  wire logic [0:0]  s_tuser,   // [0] first_segment
    // Joint output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [20:0] joint_x, [41:21] joint_y, zero pad
    output logic [0:0]       m_tuser    // [0] clipped
);
    import pcjp_pkg::*;

    localparam int POS_BITS = ANGLE_BITS - 2;
    localparam logic [SINE_TABLE_BITS:0] TAB_N = (SINE_TABLE_BITS+1)'(1 << SINE_TABLE_BITS);

    // Base point registers
    logic signed [POS_W-1:0] base_x_reg, base_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_x_reg <= '0;
            base_y_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (pcjp_cfg_t'(cfg_addr))
                CFG_BASE_X: base_x_reg <= cfg_wr_data;
                CFG_BASE_Y: base_y_reg <= cfg_wr_data;
            endcase
        end
    end

    // Pipeline handshake: a stage loads when it is empty or moving on
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic ready1, ready2, ready3, ready4;
    logic load1, load2, load3, load4;

    assign ready4   = !v4_reg || m_tready;
    assign ready3   = !v3_reg || ready4;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign s_tready = ready1;
    assign load1    = s_tvalid && ready1;
    assign load2    = v1_reg && ready2;
    assign load3    = v2_reg && ready3;
    assign load4    = v3_reg && ready4;

    assign v1_next = load1 || (v1_reg && !load2);
    assign v2_next = load2 || (v2_reg && !load3);
    assign v3_next = load3 || (v3_reg && !load4);
    assign v4_next = load4 || (v4_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // Stage 1: accumulate heading, restart it on a first segment
    logic [ANGLE_BITS-1:0] step_ext;
    logic [ANGLE_BITS-1:0] heading_reg, heading_next;
    logic [ANGLE_BITS-1:0] h1_reg;
    logic                  first1_reg;
    logic [LEN_W-1:0]      len1_reg;

    generate
        if (ANGLE_BITS <= STEP_W) begin : g_step_cut
            assign step_ext = s_tdata[ANGLE_BITS-1:0];
        end else begin : g_step_ext
            assign step_ext = {{(ANGLE_BITS-STEP_W){1'b0}}, s_tdata[STEP_W-1:0]};
        end
    endgenerate

    assign heading_next = s_tuser[0] ? step_ext : heading_reg + step_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heading_reg <= '0;
        end else if (load1) begin
            heading_reg <= heading_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load1) begin
            h1_reg     <= heading_next;
            first1_reg <= s_tuser[0];
            len1_reg   <= s_tdata[STEP_W +: LEN_W];
        end
    end

    // Stage 2: table index from the angle within the quadrant
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [SINE_TABLE_BITS:0]   addr_a, addr_b;

    generate
        if (POS_BITS >= SINE_TABLE_BITS) begin : g_idx_cut
            assign idx = h1_reg[POS_BITS-1 -: SINE_TABLE_BITS];
        end else begin : g_idx_pad
            assign idx = {h1_reg[POS_BITS-1:0], {(SINE_TABLE_BITS-POS_BITS){1'b0}}};
        end
    endgenerate

    assign addr_a = {1'b0, idx};
    assign addr_b = TAB_N - {1'b0, idx};

    logic [TRIG_W-1:0] sin_a, sin_b;
    logic [1:0]        quad2_reg;
    logic              first2_reg;
    logic [LEN_W-1:0]  len2_reg;

    pcjp_sine_rom #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_rom (
        .aclk   (aclk),
        .rd_en  (load2),
        .addr_a (addr_a),
        .addr_b (addr_b),
        .data_a (sin_a),
        .data_b (sin_b)
    );

    always_ff @(posedge aclk) begin
        if (load2) begin
            quad2_reg  <= h1_reg[ANGLE_BITS-1 -: 2];
            first2_reg <= first1_reg;
            len2_reg   <= len1_reg;
        end
    end

    // Stage 3: fold the quadrant into signs, scale by length
    logic signed [TRIG_W:0] a_s, b_s, sin_v, cos_v;
    logic signed [LEN_W:0]  len_s;
    pcjp_scaled_t           scaled_next, scaled_reg;

    assign a_s   = $signed({1'b0, sin_a});
    assign b_s   = $signed({1'b0, sin_b});
    assign len_s = $signed({1'b0, len2_reg});

    always_comb begin
        unique case (quad2_reg)
            2'd0: begin sin_v = a_s;  cos_v = b_s;  end
            2'd1: begin sin_v = b_s;  cos_v = -a_s; end
            2'd2: begin sin_v = -a_s; cos_v = -b_s; end
            2'd3: begin sin_v = -b_s; cos_v = a_s;  end
        endcase
    end

    // Add half an output step before the floor shift
    assign scaled_next.first = first2_reg;
    assign scaled_next.dx    = len_s * cos_v + PROD_W'(16384);
    assign scaled_next.dy    = len_s * sin_v + PROD_W'(16384);

    always_ff @(posedge aclk) begin
        if (load3) begin
            scaled_reg <= scaled_next;
        end
    end

    // Stage 4: saturating position accumulator and result register
    logic signed [POS_W-1:0] joint_x, joint_y;
    logic                    clipped;

    pcjp_position u_pos (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load4),
        .scaled  (scaled_reg),
        .base_x  (base_x_reg),
        .base_y  (base_y_reg),
        .joint_x (joint_x),
        .joint_y (joint_y),
        .clipped (clipped)
    );

    assign m_tvalid = v4_reg;
    assign m_tdata  = {6'd0, joint_y, joint_x};
    assign m_tuser  = clipped;

endmodule
`default_nettype wire

FILE: hdl/pcjp_sine_rom.sv
`default_nettype none
module pcjp_sine_rom #(
    parameter int TABLE_BITS = 10
) (
    input  wire logic                          aclk,
    input  wire logic                          rd_en,
    input  wire logic [TABLE_BITS:0]           addr_a,
    input  wire logic [TABLE_BITS:0]           addr_b,
    output logic      [pcjp_pkg::TRIG_W-1:0]   data_a,
    output logic      [pcjp_pkg::TRIG_W-1:0]   data_b
);
    import pcjp_pkg::*;

    localparam int DEPTH = (1 << TABLE_BITS) + 1;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic [TRIG_W-1:0] sine_tab_t [0:DEPTH-1];

    // Restoring shift-and-subtract quotient, evaluated only while the table is built
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Quarter-wave sine in Q15: Taylor series in Q30, each term truncated,
    // then rounded half up
    function automatic sine_tab_t build_tab();
        sine_tab_t          tab;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        div;
        logic signed [63:0] sum;
        logic               neg;
        for (int i = 0; i < DEPTH; i++) begin
            x    = (64'(i) * HALF_PI_Q30) >> TABLE_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            neg  = 1'b1;
            for (int k = 1; k < 40; k++) begin
                if (term != 64'd0) begin
                    div  = 64'((2 * k) * (2 * k + 1));
                    term = udiv64((term * x2) >> 30, div);
                    sum  = neg ? sum - $signed(term) : sum + $signed(term);
                    neg  = !neg;
                end
            end
            if (sum < 0) begin
                sum = 64'sd0;
            end
            tab[i] = TRIG_W'((64'(sum) + 64'd16384) >> 15);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_tab();

    // Two registered read ports
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            data_a <= SINE_TAB[addr_a];
            data_b <= SINE_TAB[addr_b];
        end
    end

endmodule
`default_nettype wire

FILE: hdl/pcjp_position.sv
`default_nettype none
module pcjp_position (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 load,
    input  wire pcjp_pkg::pcjp_scaled_t               scaled,
    input  wire logic signed [pcjp_pkg::POS_W-1:0]    base_x,
    input  wire logic signed [pcjp_pkg::POS_W-1:0]    base_y,
    output logic signed      [pcjp_pkg::POS_W-1:0]    joint_x,
    output logic signed      [pcjp_pkg::POS_W-1:0]    joint_y,
    output logic                                      clipped
);
    import pcjp_pkg::*;

    logic signed [POS_W-1:0] joint_x_reg, joint_x_next;
    logic signed [POS_W-1:0] joint_y_reg, joint_y_next;
    logic                    clipped_reg, clipped_next;
    logic signed [POS_W-1:0] start_x, start_y;
    logic signed [INC_W-1:0] inc_x, inc_y;
    logic signed [SUM_W-1:0] sum_x, sum_y;
    logic                    clip_x, clip_y;

    // Floor shift to Q.4: rounding constant was added before the shift
    assign inc_x = scaled.dx[PROD_W-1:FRAC_SHIFT];
    assign inc_y = scaled.dy[PROD_W-1:FRAC_SHIFT];

    // Start from the base point on a new chain, else from the last joint
    assign start_x = scaled.first ? base_x : joint_x_reg;
    assign start_y = scaled.first ? base_y : joint_y_reg;

    assign sum_x = SUM_W'(start_x) + SUM_W'(inc_x);
    assign sum_y = SUM_W'(start_y) + SUM_W'(inc_y);

    // Saturate each coordinate and flag it
    always_comb begin
        clip_x = 1'b0;
        clip_y = 1'b0;
        if (sum_x > SUM_W'(POS_MAX)) begin
            joint_x_next = POS_MAX;
            clip_x       = 1'b1;
        end else if (sum_x < SUM_W'(POS_MIN)) begin
            joint_x_next = POS_MIN;
            clip_x       = 1'b1;
        end else begin
            joint_x_next = sum_x[POS_W-1:0];
        end
        if (sum_y > SUM_W'(POS_MAX)) begin
            joint_y_next = POS_MAX;
            clip_y       = 1'b1;
        end else if (sum_y < SUM_W'(POS_MIN)) begin
            joint_y_next = POS_MIN;
            clip_y       = 1'b1;
        end else begin
            joint_y_next = sum_y[POS_W-1:0];
        end
        clipped_next = clip_x | clip_y;
    end

    // The result register doubles as the previous joint
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            joint_x_reg <= '0;
            joint_y_reg <= '0;
            clipped_reg <= 1'b0;
        end else if (load) begin
            joint_x_reg <= joint_x_next;
            joint_y_reg <= joint_y_next;
            clipped_reg <= clipped_next;
        end
    end

    assign joint_x = joint_x_reg;
    assign joint_y = joint_y_reg;
    assign clipped = clipped_reg;

endmodule
`default_nettype wire

FILE: dv/tb_planar_chain_joint_positions_core.sv
`default_nettype none
module tb_planar_chain_joint_positions_core;
    import pcjp_pkg::*;

    localparam int ANGLE_BITS  = 16;
    localparam int TABLE_BITS  = 10;
    localparam int TAB_N       = 1 << TABLE_BITS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic                    clipped;
    } joint_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [0:0]              cfg_addr;
    logic [POS_W-1:0]        cfg_wr_data;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [31:0]             s_tdata;   // [15:0] angle_step, [31:16] seg_length
    logic [0:0]              s_tuser;   // [0] first_segment
    logic                    m_tvalid;
    logic                    m_tready;
    logic [47:0]             m_tdata;   // [20:0] joint_x, [41:21] joint_y, zero pad
    logic [0:0]              m_tuser;   // [0] clipped

    logic signed [POS_W-1:0] got_x;
    logic signed [POS_W-1:0] got_y;

    // Predicted chain state and base point
    int unsigned             sine_q15 [0:TAB_N];
    logic [ANGLE_BITS-1:0]   heading_acc = '0;
    logic signed [POS_W-1:0] prev_x      = '0;
    logic signed [POS_W-1:0] prev_y      = '0;
    logic signed [POS_W-1:0] base_x_cfg  = '0;
    logic signed [POS_W-1:0] base_y_cfg  = '0;

    joint_t                  pending_joints [$];
    joint_t                  want;
    int                      mismatches   = 0;
    int                      cycle_count  = 0;
    int                      tx_max_gap   = 10;
    int                      rx_max_stall = 10;

    assign got_x = m_tdata[POS_W-1:0];
    assign got_y = m_tdata[2*POS_W-1:POS_W];

    planar_chain_joint_positions_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Quarter-wave sine in Q15 from a truncated Taylor series in Q30
    function automatic void build_sine_table();
        longint unsigned x, x2, term, k;
        longint          acc;
        bit              neg;
        for (int i = 0; i <= TAB_N; i++) begin
            x    = (longint'(i) * HALF_PI_Q30) >> TABLE_BITS;
            x2   = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            k    = 1;
            neg  = 1'b1;
            while (term != 0 && k < 40) begin
                term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
                acc  = neg ? acc - longint'(term) : acc + longint'(term);
                neg  = !neg;
                k++;
            end
            if (acc < 0)
                acc = 0;
            sine_q15[i] = int'((longint'(acc) + 16384) >> 15);
        end
    endfunction

    // Advance the heading and the last joint by one segment
    function automatic joint_t next_joint(input logic first, input logic [15:0] step,
                                          input logic [15:0] len);
        joint_t                       j;
        logic [ANGLE_BITS-TABLE_BITS-3+TABLE_BITS:0] pos;
        int                           idx;
        longint                       a, b, sn, cs, len_l, sx, sy, nx, ny;
        if (first) begin
            heading_acc = step[ANGLE_BITS-1:0];
            sx = base_x_cfg;
            sy = base_y_cfg;
        end else begin
            heading_acc = heading_acc + step[ANGLE_BITS-1:0];
            sx = prev_x;
            sy = prev_y;
        end
        pos = heading_acc[ANGLE_BITS-3:0];
        idx = int'(pos >> (ANGLE_BITS - 2 - TABLE_BITS)) & (TAB_N - 1);
        a = sine_q15[idx];
        b = sine_q15[TAB_N - idx];
        case (heading_acc[ANGLE_BITS-1 -: 2])
            2'd0: begin sn = a;  cs = b;  end
            2'd1: begin sn = b;  cs = -a; end
            2'd2: begin sn = -a; cs = -b; end
            default: begin sn = -b; cs = a; end
        endcase
        // Round half up to Q.4: floor of (product + half) / 2^15
        len_l = len;
        nx = sx + ((len_l * cs + 16384) >>> 15);
        ny = sy + ((len_l * sn + 16384) >>> 15);
        j.clipped = 1'b0;
        if (nx > POS_MAX) begin nx = POS_MAX; j.clipped = 1'b1; end
        if (nx < POS_MIN) begin nx = POS_MIN; j.clipped = 1'b1; end
        if (ny > POS_MAX) begin ny = POS_MAX; j.clipped = 1'b1; end
        if (ny < POS_MIN) begin ny = POS_MIN; j.clipped = 1'b1; end
        j.x    = nx[POS_W-1:0];
        j.y    = ny[POS_W-1:0];
        prev_x = j.x;
        prev_y = j.y;
        return j;
    endfunction

    // Send one segment beat after a random gap and queue its predicted joint
    task automatic send_segment(input logic first, input logic [15:0] step,
                                input logic [15:0] len);
        int     gap;
        joint_t predicted;
        gap = $urandom_range(tx_max_gap, 0);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {len, step};
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        predicted = next_joint(first, step, len);
        pending_joints.insert(pending_joints.size(), predicted);
    endtask

    // Drop valid and wait until every queued joint has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_joints.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Write both base registers, X then Y, while idle
    task automatic set_base(input logic signed [POS_W-1:0] bx,
                            input logic signed [POS_W-1:0] by);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= CFG_BASE_X;
        cfg_wr_data <= bx;
        @(posedge aclk);
        cfg_addr    <= CFG_BASE_Y;
        cfg_wr_data <= by;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        base_x_cfg  = bx;
        base_y_cfg  = by;
    endtask

    // Base at reset value: quadrants, heading wrap, zero and full lengths
    task automatic test_directed_chain();
        send_segment(1'b1, 16'h0000, 16'h0000);
        send_segment(1'b1, 16'h0000, 16'hFFFF);
        send_segment(1'b0, 16'h4000, 16'hFFFF);
        send_segment(1'b0, 16'h4000, 16'hFFFF);
        send_segment(1'b0, 16'h4000, 16'hFFFF);
        send_segment(1'b0, 16'h4000, 16'hFFFF);
        send_segment(1'b0, 16'hFFFF, 16'h0010);
        send_segment(1'b0, 16'h0001, 16'h1234);
        send_segment(1'b1, 16'h2000, 16'h0100);
        send_segment(1'b0, 16'h8000, 16'h0100);
    endtask

    // Saturation at both ends of both coordinates, and a chain running into it
    task automatic test_saturation();
        set_base(POS_MAX, POS_MAX);
        send_segment(1'b1, 16'h0000, 16'hFFFF);
        send_segment(1'b0, 16'h4000, 16'hFFFF);
        send_segment(1'b1, 16'h8000, 16'h0010);
        set_base(POS_MIN, POS_MIN);
        send_segment(1'b1, 16'h8000, 16'hFFFF);
        send_segment(1'b0, 16'h4000, 16'hFFFF);
        send_segment(1'b1, 16'h4000, 16'hFFFF);
        set_base(21'sd848575, -21'sd848576);
        send_segment(1'b1, 16'h0000, 16'hFFFF);
        for (int i = 0; i < 3; i++)
            send_segment(1'b0, 16'h0000, 16'hFFFF);
    endtask

    // Random chains under several base points and backpressure mixes
    task automatic test_random_chains();
        int                      left, chain;
        logic                    first;
        logic [15:0]             step, len;
        logic signed [POS_W-1:0] bx, by;
        for (int p = 0; p < 8; p++) begin
            bx = $urandom;
            by = $urandom;
            case (p)
                0: begin bx = '0;      by = '0;      end
                1: begin bx = POS_MAX; by = POS_MAX; end
                2: begin bx = POS_MIN; by = POS_MIN; end
                3: begin bx = POS_MAX; by = POS_MIN; end
                4: begin bx = POS_MIN; by = POS_MAX; end
                default: ;
            endcase
            set_base(bx, by);
            tx_max_gap   = (p % 2 == 0) ? 0 : 10;
            rx_max_stall = ((p / 2) % 2 == 0) ? 0 : 10;
            left = 240;
            while (left > 0) begin
                chain = ($urandom_range(7, 0) == 0) ? 1 : $urandom_range(40, 2);
                for (int j = 0; j < chain && left > 0; j++) begin
                    first = (j == 0) || ($urandom_range(15, 0) == 0);
                    case ($urandom_range(3, 0))
                        0: step = $urandom_range(255, 0);
                        1: step = 16'hFFFF - $urandom_range(255, 0);
                        2: step = {2'($urandom_range(3, 0)), 14'h0000};
                        default: step = $urandom;
                    endcase
                    case ($urandom_range(3, 0))
                        0: len = 16'hFFFF;
                        1: len = $urandom_range(64, 0);
                        2: len = $urandom_range(65535, 40000);
                        default: len = $urandom;
                    endcase
                    send_segment(first, step, len);
                    left--;
                end
            end
        end
    endtask

    // Result side: random stall before accepting each joint beat
    initial begin : result_sink
        int stall;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = $urandom_range(rx_max_stall, 0);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Compare each joint beat with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_joints.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected joint beat: x=%0d y=%0d clipped=%0b",
                             got_x, got_y, m_tuser[0]);
            end else begin
                want = pending_joints.pop_front();
                if (got_x !== want.x || got_y !== want.y || m_tuser[0] !== want.clipped) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("joint mismatch: expected x=%0d y=%0d clipped=%0b, got x=%0d y=%0d clipped=%0b",
                                 want.x, want.y, want.clipped, got_x, got_y, m_tuser[0]);
                end
            end
        end
    end

    // Hard stop for a hung handshake
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_addr    <= CFG_BASE_X;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= '0;
        build_sine_table();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_chain();
        test_saturation();
        test_random_chains();
        wait_idle();
        if (mismatches == 0 && pending_joints.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire

FILE: files.f
hdl/pcjp_pkg.sv
hdl/pcjp_sine_rom.sv
hdl/pcjp_position.sv
hdl/planar_chain_joint_positions_core.sv
dv/tb_planar_chain_joint_positions_core.sv
